### hdl/rwts_pkg.sv
// Shared types and constants for the raycast wall texel shader.
`default_nettype none
package rwts_pkg;

    localparam logic       CMD_WRITE    = 1'b0;
    localparam logic       CMD_SHADE    = 1'b1;
    localparam logic [1:0] DIR_NEG      = 2'd0;
    localparam logic [1:0] DIR_POS      = 2'd1;
    localparam logic [2:0] CODE_CLAMP   = 3'd3;
    localparam logic [2:0] BASE_DEFAULT = 3'd1;
    localparam logic [11:0] SCREEN_H_RESET = 12'd480;
    localparam logic [23:0] SHADOW_MASK = 24'h7F7F7F;
    localparam int D_W = 25;
    localparam int M_W = 24;

    typedef struct packed {
        logic        valid;
        logic        shade;
        logic        wr_ok;
        logic        drawn;
        logic [2:0]  slot;
        logic        shadow;
        logic [9:0]  col;
        logic [11:0] y;
        logic [23:0] color;
        logic [11:0] addr;
    } rwts_ctl_t;

endpackage
`default_nettype wire

### hdl/rwts_front.sv
// Input stage: texture choice, texture column and row offset numerator.
`default_nettype none
module rwts_front #(
    parameter int TEX_SIZE  = 64,
    parameter int TEX_SLOTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            take,
    input  logic [11:0]                     screen_height,
    input  logic                            command,
    input  logic [2:0]                      tex_select,
    input  logic [11:0]                     texel_addr,
    input  logic [23:0]                     texel_color,
    input  logic [9:0]                      column,
    input  logic [11:0]                     row,
    input  logic [15:0]                     line_height,
    input  logic                            side,
    input  logic [1:0]                      ray_dir_sign,
    input  logic [15:0]                     wall_fraction,
    input  logic                            shadow,
    output rwts_pkg::rwts_ctl_t             ctl_out,
    output logic [$clog2(TEX_SIZE)-1:0]     tcol_out,
    output logic [rwts_pkg::D_W-1:0]        d_out,
    output logic [15:0]                     l_out
);
    import rwts_pkg::*;

    localparam int QW   = $clog2(TEX_SIZE);
    localparam int AREA = TEX_SIZE * TEX_SIZE;

    rwts_ctl_t       ctl_reg;
    logic [QW-1:0]   tcol_reg;
    logic [D_W-1:0]  d_reg;
    logic [15:0]     l_reg;

    logic [2:0]      base;
    logic [2:0]      offset;
    logic [2:0]      slot;
    logic            mirror;
    logic [23:0]     frac_prod;
    logic [QW-1:0]   tcol_raw;
    logic [QW-1:0]   tcol;
    logic [D_W-1:0]  d;
    rwts_ctl_t       ctl_next;

    always_comb
    begin
        base = (tex_select >= CODE_CLAMP) ? BASE_DEFAULT : tex_select;
        if (side)
            offset = (ray_dir_sign[0] == DIR_NEG[0]) ? 3'd0 : 3'd2;
        else
            offset = (ray_dir_sign[0] == DIR_NEG[0]) ? 3'd3 : 3'd1;
        slot      = base + offset;
        mirror    = side ^ ray_dir_sign[0];
        frac_prod = 24'(wall_fraction) * 24'(TEX_SIZE);
        tcol_raw  = frac_prod[16 +: QW];
        tcol      = mirror ? (QW'(TEX_SIZE - 1) - tcol_raw) : tcol_raw;
        d = {5'b0, row, 8'b0} - {6'b0, screen_height, 7'b0} + {2'b0, line_height, 7'b0};

        ctl_next.valid  = take;
        ctl_next.shade  = (command == CMD_SHADE);
        ctl_next.wr_ok  = (32'(tex_select) < TEX_SLOTS) && (32'(texel_addr) < AREA);
        ctl_next.drawn  = (ray_dir_sign == DIR_NEG || ray_dir_sign == DIR_POS)
                          && (32'(slot) < TEX_SLOTS);
        ctl_next.slot   = ctl_next.shade ? slot : tex_select;
        ctl_next.shadow = shadow;
        ctl_next.col    = column;
        ctl_next.y      = row;
        ctl_next.color  = texel_color;
        ctl_next.addr   = texel_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tcol_reg <= tcol;
            d_reg    <= d;
            l_reg    <= line_height;
        end
    end

    assign ctl_out  = ctl_reg;
    assign tcol_out = tcol_reg;
    assign d_out    = d_reg;
    assign l_out    = l_reg;

endmodule
`default_nettype wire

### hdl/rwts_row_div.sv
// Pipelined restoring divider that yields the saturated texture row.
`default_nettype none
module rwts_row_div #(
    parameter int TEX_SIZE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  rwts_pkg::rwts_ctl_t             ctl_in,
    input  logic [$clog2(TEX_SIZE)-1:0]     tcol_in,
    input  logic [rwts_pkg::D_W-1:0]        d_in,
    input  logic [15:0]                     l_in,
    output rwts_pkg::rwts_ctl_t             ctl_out,
    output logic [$clog2(TEX_SIZE)-1:0]     tcol_out,
    output logic [$clog2(TEX_SIZE)-1:0]     row_out
);
    import rwts_pkg::*;

    localparam int QW = $clog2(TEX_SIZE);
    localparam int NW = M_W + QW;

    rwts_ctl_t       ctl_reg  [0:QW];
    logic [QW-1:0]   tcol_reg [0:QW];
    logic [NW-1:0]   rem_reg  [0:QW];
    logic [M_W-1:0]  div_reg  [0:QW];
    logic [QW-1:0]   q_reg    [0:QW];
    logic            zero_reg [0:QW];
    logic            sat_reg  [0:QW];

    logic [M_W-1:0]  div_in;

    assign div_in = {l_in, 8'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg[0] <= '0;
        else if (en)
            ctl_reg[0] <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tcol_reg[0] <= tcol_in;
            rem_reg[0]  <= NW'(d_in[M_W-1:0]) * NW'(TEX_SIZE);
            div_reg[0]  <= div_in;
            q_reg[0]    <= '0;
            zero_reg[0] <= (l_in == 16'd0) || d_in[D_W-1];
            sat_reg[0]  <= (d_in[M_W-1:0] >= div_in);
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++)
        begin : g_stage
            logic [NW-1:0] trial;
            logic          ge;

            assign trial = NW'(div_reg[k-1]) << (QW - k);
            assign ge    = (rem_reg[k-1] >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    ctl_reg[k] <= '0;
                else if (en)
                    ctl_reg[k] <= ctl_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tcol_reg[k] <= tcol_reg[k-1];
                    rem_reg[k]  <= ge ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                    div_reg[k]  <= div_reg[k-1];
                    q_reg[k]    <= q_reg[k-1] | (ge ? (QW'(1) << (QW - k)) : QW'(0));
                    zero_reg[k] <= zero_reg[k-1];
                    sat_reg[k]  <= sat_reg[k-1];
                end
            end
        end
    endgenerate

    assign ctl_out  = ctl_reg[QW];
    assign tcol_out = tcol_reg[QW];
    assign row_out  = zero_reg[QW] ? QW'(0)
                    : (sat_reg[QW] ? QW'(TEX_SIZE - 1) : q_reg[QW]);

endmodule
`default_nettype wire

### hdl/rwts_tex_mem.sv
// Texture store access and shading of the fetched texel.
`default_nettype none
module rwts_tex_mem #(
    parameter int TEX_SIZE  = 64,
    parameter int TEX_SLOTS = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  rwts_pkg::rwts_ctl_t             ctl_in,
    input  logic [$clog2(TEX_SIZE)-1:0]     tcol_in,
    input  logic [$clog2(TEX_SIZE)-1:0]     row_in,
    output logic                            res_valid,
    output logic [23:0]                     res_color,
    output logic                            res_drawn,
    output logic [9:0]                      res_column,
    output logic [11:0]                     res_row
);
    import rwts_pkg::*;

    localparam int AREA  = TEX_SIZE * TEX_SIZE;
    localparam int DEPTH = TEX_SLOTS * AREA;
    localparam int AW    = $clog2(DEPTH);

    logic [23:0]  mem [0:DEPTH-1];
    logic [23:0]  rd_data_reg;
    rwts_ctl_t    ctl_reg;

    logic [AW-1:0] slot_base;
    logic [AW-1:0] acc_addr;
    logic [23:0]   shaded;

    always_comb
    begin
        slot_base = AW'(ctl_in.slot) * AW'(AREA);
        if (ctl_in.shade)
            acc_addr = slot_base + AW'(row_in) * AW'(TEX_SIZE) + AW'(tcol_in);
        else
            acc_addr = slot_base + AW'(ctl_in.addr);
    end

    always_ff @(posedge clk)
    begin
        if (en && ctl_in.valid)
        begin
            if (ctl_in.shade == CMD_WRITE && ctl_in.wr_ok)
                mem[acc_addr] <= ctl_in.color;
            if (ctl_in.shade == CMD_SHADE && ctl_in.drawn)
                rd_data_reg <= mem[acc_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    assign shaded     = ctl_reg.shadow ? ((rd_data_reg >> 1) & SHADOW_MASK) : rd_data_reg;
    assign res_valid  = ctl_reg.valid && (ctl_reg.shade == CMD_SHADE);
    assign res_color  = ctl_reg.drawn ? shaded : 24'd0;
    assign res_drawn  = ctl_reg.drawn;
    assign res_column = ctl_reg.col;
    assign res_row    = ctl_reg.y;

endmodule
`default_nettype wire

### hdl/raycast_wall_texel_shader.sv
// Top level of the raycast wall texel shader with output skid buffer.
//
//  channel   signals                              direction
//  input     in_valid / in_stall + item fields    into block
//  output    out_valid / out_stall + result       out of block
//  config    cfg_write_en / cfg_write_data        into block
//
// One item per cycle while in_stall is low; a shade result passes the front
// register, the one-bit-per-stage row divider and the texture read register.
// Write items update the store at the same stage where shade items read it.
// Reset clears control state only; the texture store needs no clearing pass.
// in_stall rises only when both output registers hold results.
`default_nettype none
module raycast_wall_texel_shader #(
    parameter int TEX_SIZE  = 64,
    parameter int TEX_SLOTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [11:0] cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [2:0]  tex_select,
    input  logic [11:0] texel_addr,
    input  logic [23:0] texel_color,
    input  logic [9:0]  column,
    input  logic [11:0] row,
    input  logic [15:0] line_height,
    input  logic        side,
    input  logic [1:0]  ray_dir_sign,
    input  logic [15:0] wall_fraction,
    input  logic        shadow,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] pixel_color,
    output logic        drawn,
    output logic [9:0]  out_column,
    output logic [11:0] out_row
);
    import rwts_pkg::*;

    localparam int QW = $clog2(TEX_SIZE);

    logic [11:0]     screen_height_reg;
    logic            pipe_en;
    logic            take;

    rwts_ctl_t       f_ctl;
    logic [QW-1:0]   f_tcol;
    logic [D_W-1:0]  f_d;
    logic [15:0]     f_l;

    rwts_ctl_t       v_ctl;
    logic [QW-1:0]   v_tcol;
    logic [QW-1:0]   v_row;

    logic            res_valid;
    logic [23:0]     res_color;
    logic            res_drawn;
    logic [9:0]      res_column;
    logic [11:0]     res_row;

    logic            out_valid_reg;
    logic [23:0]     out_color_reg;
    logic            out_drawn_reg;
    logic [9:0]      out_column_reg;
    logic [11:0]     out_row_reg;
    logic            spare_valid_reg;
    logic [23:0]     spare_color_reg;
    logic            spare_drawn_reg;
    logic [9:0]      spare_column_reg;
    logic [11:0]     spare_row_reg;

    logic            pop;
    logic            push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            screen_height_reg <= SCREEN_H_RESET;
        else if (cfg_write_en)
            screen_height_reg <= cfg_write_data;
    end

    assign pipe_en  = !spare_valid_reg;
    assign in_stall = spare_valid_reg;
    assign take     = in_valid && !in_stall;

    rwts_front #(
        .TEX_SIZE  (TEX_SIZE),
        .TEX_SLOTS (TEX_SLOTS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (pipe_en),
        .take          (take),
        .screen_height (screen_height_reg),
        .command       (command),
        .tex_select    (tex_select),
        .texel_addr    (texel_addr),
        .texel_color   (texel_color),
        .column        (column),
        .row           (row),
        .line_height   (line_height),
        .side          (side),
        .ray_dir_sign  (ray_dir_sign),
        .wall_fraction (wall_fraction),
        .shadow        (shadow),
        .ctl_out       (f_ctl),
        .tcol_out      (f_tcol),
        .d_out         (f_d),
        .l_out         (f_l)
    );

    rwts_row_div #(
        .TEX_SIZE (TEX_SIZE)
    ) u_row_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (pipe_en),
        .ctl_in   (f_ctl),
        .tcol_in  (f_tcol),
        .d_in     (f_d),
        .l_in     (f_l),
        .ctl_out  (v_ctl),
        .tcol_out (v_tcol),
        .row_out  (v_row)
    );

    rwts_tex_mem #(
        .TEX_SIZE  (TEX_SIZE),
        .TEX_SLOTS (TEX_SLOTS)
    ) u_tex_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (pipe_en),
        .ctl_in     (v_ctl),
        .tcol_in    (v_tcol),
        .row_in     (v_row),
        .res_valid  (res_valid),
        .res_color  (res_color),
        .res_drawn  (res_drawn),
        .res_column (res_column),
        .res_row    (res_row)
    );

    assign pop  = out_valid_reg && !out_stall;
    assign push = pipe_en && res_valid;

    // Hold a second result when the main output register is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (spare_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
            out_valid_reg <= push;
        else if (push)
            spare_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (spare_valid_reg)
        begin
            if (pop)
            begin
                out_color_reg  <= spare_color_reg;
                out_drawn_reg  <= spare_drawn_reg;
                out_column_reg <= spare_column_reg;
                out_row_reg    <= spare_row_reg;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            if (push)
            begin
                out_color_reg  <= res_color;
                out_drawn_reg  <= res_drawn;
                out_column_reg <= res_column;
                out_row_reg    <= res_row;
            end
        end
        else if (push)
        begin
            spare_color_reg  <= res_color;
            spare_drawn_reg  <= res_drawn;
            spare_column_reg <= res_column;
            spare_row_reg    <= res_row;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = out_color_reg;
    assign drawn       = out_drawn_reg;
    assign out_column  = out_column_reg;
    assign out_row     = out_row_reg;

endmodule
`default_nettype wire
